@@ rtl/core/alb_pkg.sv @@
// Shared types and constants for the ambient light brightness tracker.
// No dependencies; imported by every module under rtl/core.
package alb_pkg;

    localparam int SAMPLE_W   = 10;                    // light sample width
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;   // 1023
    localparam int LEVEL_W    = 5;                     // signed brightness level
    localparam int CFG_W      = 4;                     // widest register
    localparam int CFG_IDX_W  = 2;

    // Inverse map span: (avg - 1) * (lo - hi) / (1024 - 1)
    localparam int IN_SPAN    = 1023;
    localparam int SPAN_W     = CFG_W + 2;             // lo - hi, signed
    localparam int PROD_W     = 15;                    // |(avg - 1) * (lo - hi)| < 2**15
    localparam int SPAN_SHIFT = PROD_W + 10;
    localparam int SPAN_RECIP = ((1 << SPAN_SHIFT) + IN_SPAN - 1) / IN_SPAN;
    localparam int RECIP_W    = 16;
    localparam int QUOT_W     = 6;                     // signed quotient, |q| <= 16
    localparam int TGT_W      = 7;                     // unclamped target, signed

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AUTO_ENABLE  = 2'd0,
        REG_MANUAL_LEVEL = 2'd1,
        REG_MIN_LEVEL    = 2'd2,
        REG_MAX_LEVEL    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             auto_enable;
        logic [CFG_W-1:0] manual_level;
        logic [CFG_W-1:0] min_level;
        logic [CFG_W-1:0] max_level;
    } cfg_t;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic signed [QUOT_W-1:0]  quot_t;

endpackage

@@ rtl/core/alb_window.sv @@
// Input register, sample window memory and running sum.
// Depends on alb_pkg.
module alb_window import alb_pkg::*; #(
    parameter int WINDOW_LEN = 10,
    parameter int SUM_W      = 14
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SAMPLE_W-1:0] in_sample,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SUM_W-1:0] out_sum,
    output logic             out_manual
);

    localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

    logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s2_valid_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic                s2_manual_reg;

    logic [IDX_W-1:0]    idx_reg, idx_next, rd_addr;
    logic [SUM_W-1:0]    sum_reg, sum_update, sample_ext;
    logic                filled_reg, wrapped_reg;
    logic [SAMPLE_W-1:0] fill_value_reg, rd_data_reg, old_sample;

    logic s2_ready, s1_fire, upd;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign upd      = s1_fire && cfg.auto_enable;

    assign idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
    // keep the read data one step ahead of the write pointer
    assign rd_addr  = upd ? idx_next : idx_reg;

    // entries not yet overwritten since the first fill still hold the fill value
    always_comb begin
        if (!filled_reg) begin
            old_sample = s1_sample_reg;
        end else if (wrapped_reg) begin
            old_sample = rd_data_reg;
        end else begin
            old_sample = fill_value_reg;
        end
    end

    assign sample_ext = SUM_W'(s1_sample_reg);
    assign sum_update = filled_reg ? (sum_reg - SUM_W'(old_sample) + sample_ext)
                                   : (sample_ext * SUM_W'(WINDOW_LEN));

    always_ff @(posedge aclk) begin
        if (upd) begin
            win_mem[idx_reg] <= s1_sample_reg;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            sum_reg      <= '0;
            filled_reg   <= 1'b0;
            wrapped_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (upd) begin
                idx_reg    <= idx_next;
                sum_reg    <= sum_update;
                filled_reg <= 1'b1;
                if (idx_reg == IDX_LAST) begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            s1_sample_reg <= in_sample;
        end
        if (upd && !filled_reg) begin
            fill_value_reg <= s1_sample_reg;
        end
        if (s1_fire) begin
            s2_sum_reg    <= sum_update;
            s2_manual_reg <= !cfg.auto_enable;
        end
    end

    assign out_valid  = s2_valid_reg;
    assign out_sum    = s2_sum_reg;
    assign out_manual = s2_manual_reg;

endmodule

@@ rtl/core/alb_scale.sv @@
// Average by reciprocal multiply, then inverse linear map with truncating divide.
// Depends on alb_pkg.
module alb_scale import alb_pkg::*; #(
    parameter int WINDOW_LEN = 10,
    parameter int SUM_W      = 14
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [SUM_W-1:0] in_sum,
    input  logic             in_manual,
    output logic             out_valid,
    input  logic             out_ready,
    output quot_t            out_quot,
    output logic             out_manual
);

    localparam int LOG_N   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int AVG_K   = SUM_W + LOG_N;
    localparam int ARECIP_W = SUM_W + 1;
    localparam int APROD_W = SUM_W + ARECIP_W;
    localparam logic [ARECIP_W-1:0] AVG_RECIP =
        ARECIP_W'(((1 << AVG_K) + WINDOW_LEN - 1) / WINDOW_LEN);
    localparam int FULL_W  = SAMPLE_W + 1 + SPAN_W;
    localparam int QPROD_W = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SPAN_RECIP_C = RECIP_W'(SPAN_RECIP);

    logic                     s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic                     s3_manual_reg, s4_manual_reg, s5_manual_reg;
    logic [SAMPLE_W-1:0]      s3_avg_reg;
    logic signed [PROD_W:0]   s4_prod_reg;
    quot_t                    s5_quot_reg;

    logic r3, r4, r5;
    logic [APROD_W-1:0]       avg_prod;
    logic signed [SAMPLE_W:0] avg_m1;
    logic signed [SPAN_W-1:0] span;
    logic signed [FULL_W-1:0] map_prod;
    logic                     prod_neg;
    logic [PROD_W-1:0]        prod_mag;
    logic [QPROD_W-1:0]       quot_prod;
    quot_t                    quot_mag, quot_next;

    assign r5 = !s5_valid_reg || out_ready;
    assign r4 = !s4_valid_reg || r5;
    assign r3 = !s3_valid_reg || r4;
    assign in_ready = r3;

    // floor(sum / N) exact over the whole sum range
    assign avg_prod = APROD_W'(in_sum) * APROD_W'(AVG_RECIP);

    assign avg_m1   = $signed({1'b0, s3_avg_reg}) - $signed((SAMPLE_W + 1)'(1));
    assign span     = $signed({2'b00, cfg.min_level}) - $signed(SPAN_W'(1))
                    - $signed({2'b00, cfg.max_level});
    assign map_prod = avg_m1 * span;

    // truncate toward zero: divide the magnitude, restore the sign
    assign prod_neg  = s4_prod_reg[PROD_W];
    assign prod_mag  = prod_neg ? PROD_W'(-s4_prod_reg) : PROD_W'(s4_prod_reg);
    assign quot_prod = QPROD_W'(prod_mag) * QPROD_W'(SPAN_RECIP_C);
    assign quot_mag  = $signed({1'b0, quot_prod[SPAN_SHIFT +: QUOT_W-1]});
    assign quot_next = prod_neg ? -quot_mag : quot_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else begin
            if (r3) begin
                s3_valid_reg <= in_valid;
            end
            if (r4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (r5) begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && r3) begin
            s3_avg_reg    <= avg_prod[AVG_K +: SAMPLE_W];
            s3_manual_reg <= in_manual;
        end
        if (s3_valid_reg && r4) begin
            s4_prod_reg   <= $signed(map_prod[PROD_W:0]);
            s4_manual_reg <= s3_manual_reg;
        end
        if (s4_valid_reg && r5) begin
            s5_quot_reg   <= quot_next;
            s5_manual_reg <= s4_manual_reg;
        end
    end

    assign out_valid  = s5_valid_reg;
    assign out_quot   = s5_quot_reg;
    assign out_manual = s5_manual_reg;

endmodule

@@ rtl/core/alb_level.sv @@
// Target clamp, one-step level tracking and the result register.
// Depends on alb_pkg.
module alb_level import alb_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  quot_t  in_quot,
    input  logic   in_manual,
    output logic   out_valid,
    input  logic   out_ready,
    output level_t out_level,
    output logic   out_level_written,
    output level_t out_target_level
);

    logic   out_valid_reg;
    level_t level_out_reg, target_out_reg;
    logic   written_out_reg;
    level_t cur_level_reg, cur_level_next;
    logic   changed;
    logic   fire;

    logic signed [TGT_W-1:0] hi, lo, t_raw, t_clamp;
    level_t target;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign hi    = $signed({3'b000, cfg.max_level});
    assign lo    = $signed({3'b000, cfg.min_level}) - $signed(TGT_W'(1));
    assign t_raw = TGT_W'(in_quot) + hi;

    // lower bound wins when the bounds cross
    always_comb begin
        if (t_raw < lo) begin
            t_clamp = lo;
        end else if (t_raw > hi) begin
            t_clamp = hi;
        end else begin
            t_clamp = t_raw;
        end
    end

    assign target = $signed(t_clamp[LEVEL_W-1:0]);

    always_comb begin
        cur_level_next = cur_level_reg;
        changed        = 1'b0;
        if (target > cur_level_reg) begin
            cur_level_next = cur_level_reg + LEVEL_W'(1);
            changed        = 1'b1;
        end else if (target < cur_level_reg) begin
            cur_level_next = cur_level_reg - LEVEL_W'(1);
            changed        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cur_level_reg <= '0;
        end else begin
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
            if (fire && !in_manual) begin
                cur_level_reg <= cur_level_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (in_manual) begin
                level_out_reg   <= $signed({1'b0, cfg.manual_level});
                written_out_reg <= 1'b1;
                target_out_reg  <= '0;
            end else begin
                level_out_reg   <= cur_level_next;
                written_out_reg <= changed;
                target_out_reg  <= target;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_level         = level_out_reg;
    assign out_level_written = written_out_reg;
    assign out_target_level  = target_out_reg;

endmodule

@@ rtl/core/ambient_light_brightness_tracker.sv @@
// Ambient light brightness tracker: moving-average light level to display brightness.
// Stages: input register, window sum, average, map product, quotient, result register.
// Throughput: one sample per cycle absent back-pressure; the window memory is read
//   one entry ahead of the write pointer: its single read port never holds the pipe.
// Reset (aresetn, synchronous, active low) clears the pipe, the window fill state,
//   the running sum, the level and the registers to their defaults. No clearing pass.
module ambient_light_brightness_tracker import alb_pkg::*; #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // sample beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_light_sample,
    // result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [LEVEL_W-1:0] m_level,
    output logic                  m_level_written,
    output logic signed [LEVEL_W-1:0] m_target_level
);

    // running sum must hold WINDOW_LEN full-scale samples
    localparam int SUM_W = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);

    cfg_t cfg_reg;

    // window -> scale
    logic             win_valid, win_ready, win_manual;
    logic [SUM_W-1:0] win_sum;
    // scale -> level
    logic             scl_valid, scl_ready, scl_manual;
    quot_t            scl_quot;

    // Register writes. It is up to the user that they are only taken while no beat
    // is in flight, so every stage can read the live register values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_enable  <= 1'b1;
            cfg_reg.manual_level <= CFG_W'(8);
            cfg_reg.min_level    <= '0;
            cfg_reg.max_level    <= CFG_W'(15);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_AUTO_ENABLE:  cfg_reg.auto_enable  <= cfg_wdata[0];
                REG_MANUAL_LEVEL: cfg_reg.manual_level <= cfg_wdata;
                REG_MIN_LEVEL:    cfg_reg.min_level    <= cfg_wdata;
                REG_MAX_LEVEL:    cfg_reg.max_level    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register, then window update and running sum. The first auto beat
    // seeds the whole window; a manual beat leaves the window untouched.
    alb_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_sample  (s_light_sample),
        .out_valid  (win_valid),
        .out_ready  (win_ready),
        .out_sum    (win_sum),
        .out_manual (win_manual)
    );

    // Three stages: average, map product, signed divide by the input span.
    alb_scale #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (win_valid),
        .in_ready   (win_ready),
        .in_sum     (win_sum),
        .in_manual  (win_manual),
        .out_valid  (scl_valid),
        .out_ready  (scl_ready),
        .out_quot   (scl_quot),
        .out_manual (scl_manual)
    );

    // Clamp, single step of the applied level, result register.
    alb_level u_level (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .in_valid          (scl_valid),
        .in_ready          (scl_ready),
        .in_quot           (scl_quot),
        .in_manual         (scl_manual),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .out_level         (m_level),
        .out_level_written (m_level_written),
        .out_target_level  (m_target_level)
    );

    // An unchanged auto level has already reached its target.
    a_hold_means_on_target: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_level_written) |-> (m_level == m_target_level))
        else $error("level held while away from target");

    // The applied level never wraps below minus one.
    a_level_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_level) >= $signed(LEVEL_W'(-1))))
        else $error("level below minus one");

    // Input stalls only when the whole pipe is full behind a waiting result.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with room in the pipe");

endmodule

@@ dv/alb_brightness_checker.sv @@
// Result checker for the ambient light brightness tracker: predicts every result beat
// from the sample and register traffic it observes, and compares in order.
// Depends on alb_pkg for the field widths, level type and register indexes.
`timescale 1ns / 100ps

module alb_brightness_checker import alb_pkg::*; #(
    parameter int WINDOW_LEN = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [SAMPLE_W-1:0]       s_light_sample,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [LEVEL_W-1:0] m_level,
    input  logic                      m_level_written,
    input  logic signed [LEVEL_W-1:0] m_target_level,
    output int                        fail_count,
    output int                        pending,
    output int                        n_checked
);

    typedef struct packed {
        level_t level;
        logic   written;
        level_t target;
    } brightness_t;

    brightness_t         brightness_q[$];
    cfg_t                regs;
    logic [SAMPLE_W-1:0] window [WINDOW_LEN];
    int                  win_idx;
    int                  win_sum;
    bit                  win_full;
    int                  cur_level;

    task automatic report_mismatch(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fail_count++;
    endtask

    // Moving average -> inverse linear map -> clamp -> single step of the level.
    function automatic brightness_t track_sample(input logic [SAMPLE_W-1:0] smp);
        brightness_t r;
        int          avg;
        int          hi;
        int          lo;
        int          tgt;
        if (!regs.auto_enable) begin
            r.level   = level_t'({1'b0, regs.manual_level});
            r.written = 1'b1;
            r.target  = '0;
            return r;
        end
        if (!win_full) begin
            for (int i = 0; i < WINDOW_LEN; i++) window[i] = smp;
            win_sum  = int'(smp) * WINDOW_LEN;
            win_full = 1'b1;
        end
        if (win_idx >= WINDOW_LEN) win_idx = 0;
        win_sum         = win_sum - int'(window[win_idx]) + int'(smp);
        window[win_idx] = smp;
        win_idx         = win_idx + 1;
        if (win_idx >= WINDOW_LEN) win_idx = 0;
        avg = win_sum / WINDOW_LEN;
        hi  = int'(regs.max_level);
        lo  = int'(regs.min_level) - 1;
        // signed int division truncates toward zero
        tgt = (avg - 1) * (lo - hi) / IN_SPAN + hi;
        if (tgt < lo) tgt = lo;
        else if (tgt > hi) tgt = hi;
        r.written = 1'b1;
        if (tgt > cur_level) cur_level++;
        else if (tgt < cur_level) cur_level--;
        else r.written = 1'b0;
        r.level  = level_t'(cur_level);
        r.target = level_t'(tgt);
        return r;
    endfunction

    always @(posedge aclk) begin
        brightness_t w;
        if (!aresetn) begin
            brightness_q.delete();
            regs       = '{1'b1, 4'd8, 4'd0, 4'd15};
            win_idx    = 0;
            win_sum    = 0;
            win_full   = 1'b0;
            cur_level  = 0;
            fail_count = 0;
            n_checked  = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_AUTO_ENABLE:  regs.auto_enable  = cfg_wdata[0];
                    REG_MANUAL_LEVEL: regs.manual_level = cfg_wdata;
                    REG_MIN_LEVEL:    regs.min_level    = cfg_wdata;
                    REG_MAX_LEVEL:    regs.max_level    = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (brightness_q.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding");
                end else begin
                    w = brightness_q.pop_front();
                    n_checked++;
                    if (m_level !== w.level)
                        report_mismatch($sformatf("level got %0d want %0d",
                                                  m_level, w.level));
                    if (m_level_written !== w.written)
                        report_mismatch($sformatf("level_written got %b want %b",
                                                  m_level_written, w.written));
                    if (m_target_level !== w.target)
                        report_mismatch($sformatf("target_level got %0d want %0d",
                                                  m_target_level, w.target));
                end
            end
            if (s_valid && s_ready)
                brightness_q.push_back(track_sample(s_light_sample));
        end
        pending = brightness_q.size();
    end

endmodule

@@ dv/tb_ambient_light_brightness_tracker.sv @@
// Testbench top for the ambient light brightness tracker: drives sample beats, register
// writes and result back-pressure, and gives the verdict.
// Depends on alb_pkg, the tracker RTL and alb_brightness_checker.
`timescale 1ns / 100ps

module tb_ambient_light_brightness_tracker;
    import alb_pkg::*;

    localparam int WINDOW_LEN = 10;
    localparam int LONG_HOLD  = 300;    // cycles of result back-pressure for the fill test
    localparam int TAIL_WAIT  = 10;     // drain margin past the block's pipeline registers

    // Shapes of random sample sequences
    typedef enum int {
        SHAPE_NOISE,    // uniform over the full 10-bit range
        SHAPE_STEADY,   // near one base value: level settles, no-change results
        SHAPE_RAMP,     // slow climb with wrap: level tracks step by step
        SHAPE_EXTREME   // darkness or saturation only
    } stim_shape_t;

    logic                      aclk           = 1'b0;
    logic                      aresetn        = 1'b0;
    logic                      cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [CFG_W-1:0]          cfg_wdata      = '0;
    logic                      s_valid        = 1'b0;
    logic                      s_ready;
    logic [SAMPLE_W-1:0]       s_light_sample = '0;
    logic                      m_valid;
    logic                      m_ready        = 1'b0;
    logic signed [LEVEL_W-1:0] m_level;
    logic                      m_level_written;
    logic signed [LEVEL_W-1:0] m_target_level;

    int fail_count;
    int pending;
    int n_checked;

    // Idle and stall rates in percent; only the stimulus process writes these
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // Long hold-off handshake: the stimulus bumps the request, the receiver acks it
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    int n_sent     = 0;
    int n_settings = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    ambient_light_brightness_tracker #(
        .WINDOW_LEN      (WINDOW_LEN)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_light_sample  (s_light_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_level_written (m_level_written),
        .m_target_level  (m_target_level)
    );

    alb_brightness_checker #(
        .WINDOW_LEN      (WINDOW_LEN)
    ) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_light_sample  (s_light_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_level         (m_level),
        .m_level_written (m_level_written),
        .m_target_level  (m_target_level),
        .fail_count      (fail_count),
        .pending         (pending),
        .n_checked       (n_checked)
    );

    // Result side: random stalls, or a long counted hold-off when one is requested.
    // Sole driver of m_ready; changes on the falling edge.
    always @(negedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Offer one sample beat. Entered and left on a falling edge; valid is left high so
    // that a following beat can go back to back without dropping it.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_light_sample = smp;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_sent++;
    endtask

    // Stop offering and let every outstanding result drain.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Registers are only touched with the pipe empty
    task automatic set_config(input logic auto_on, input logic [CFG_W-1:0] manual,
                              input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        wait_idle();
        write_reg(REG_AUTO_ENABLE,  {3'b000, auto_on});
        write_reg(REG_MANUAL_LEVEL, manual);
        write_reg(REG_MIN_LEVEL,    lo);
        write_reg(REG_MAX_LEVEL,    hi);
        n_settings++;
    endtask

    task automatic run_segment(input int n_items, input stim_shape_t shape);
        int base;
        int v;
        base = $urandom_range(SAMPLE_MAX);
        for (int k = 0; k < n_items; k++) begin
            case (shape)
                SHAPE_NOISE:  v = $urandom_range(SAMPLE_MAX);
                SHAPE_STEADY: v = base + $urandom_range(16) - 8;
                SHAPE_RAMP:   v = (base + k * 9) % (SAMPLE_MAX + 1);
                default:      v = $urandom_range(1) ? SAMPLE_MAX - $urandom_range(3)
                                                    : $urandom_range(3);
            endcase
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX) v = SAMPLE_MAX;
            send_sample(v[SAMPLE_W-1:0]);
        end
    endtask

    // Run limit, far beyond the slowest legal run
    initial begin
        #3_200_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int          pick;
        logic [3:0]  lo;
        logic [3:0]  hi;
        stim_shape_t shape;

        // Reset held from the start, released on a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // ---- directed part, no idling ----
        // Reset defaults: auto on, bounds 0..15. First beat fills the window with a
        // zero sample, so the average is zero and the map sees avg - 1 = -1.
        send_sample(10'd0);
        send_sample(10'd0);
        // full brightness pulls the target down, level steps one at a time
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd1);
        send_sample(10'd512);
        send_sample(10'd1023);
        // inverted bounds: min - 1 above max, lower clamp wins
        set_config(1'b1, 4'd8, 4'd15, 4'd0);
        send_sample(10'd300);
        send_sample(10'd0);
        send_sample(10'd1023);
        // min at zero and max at zero: lower bound is -1, yet the target stays at zero
        set_config(1'b1, 4'd8, 4'd0, 4'd0);
        send_sample(10'd1023);
        send_sample(10'd0);
        set_config(1'b1, 4'd8, 4'd15, 4'd15);
        send_sample(10'd700);
        send_sample(10'd0);
        // manual mode at both extremes of manual_level; state must stay put
        set_config(1'b0, 4'd0, 4'd0, 4'd15);
        send_sample(10'd1023);
        send_sample(10'd5);
        set_config(1'b0, 4'd15, 4'd0, 4'd15);
        send_sample(10'd0);
        // back to auto: window is already full, no refill
        set_config(1'b1, 4'd8, 4'd0, 4'd15);
        send_sample(10'd1023);
        send_sample(10'd512);

        // ---- random part: 16 segments, each with its own register setting ----
        for (int seg = 0; seg < 16; seg++) begin
            pick = $urandom_range(9);
            lo   = 4'($urandom_range(15));
            hi   = 4'($urandom_range(15));
            case (pick)
                0:       set_config(1'b0, 4'($urandom_range(15)), lo, hi);
                1:       set_config(1'b1, 4'($urandom_range(15)), 4'd0, 4'd15);
                2:       set_config(1'b1, 4'($urandom_range(15)), 4'd15, 4'd0);
                3:       set_config(1'b1, 4'($urandom_range(15)), 4'd15, 4'd15);
                4:       set_config(1'b1, 4'($urandom_range(15)), lo, hi);
                default: set_config(1'b1, 4'($urandom_range(15)), (lo < hi) ? lo : hi,
                                    (lo < hi) ? hi : lo);
            endcase
            // idling pattern rotates: none, sender gaps, receiver stalls, both light
            case (seg % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
                default: begin tx_idle_pct = 6; rx_stall_pct = 6; end
            endcase
            // one segment holds off results for a long stretch while samples keep
            // coming, so the pipe fills and s_ready must drop
            if (seg == 4) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
                hold_req     = hold_req + 1;
            end
            shape = stim_shape_t'($urandom_range(3));
            run_segment(100 + $urandom_range(20), shape);
        end

        // ---- drain ----
        wait_idle();
        repeat (TAIL_WAIT) @(negedge aclk);

        $display("Covered %0d sample beats over %0d register settings (auto and manual,",
                 n_sent, n_settings);
        $display("inverted and extreme bounds, long result hold-off); %0d results checked.",
                 n_checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
